// ===== rtl/nla_pkg.sv =====
package nla_pkg;

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   localparam int ID_W   = 16;
   localparam int POS_W  = 24;
   localparam int DIFF_W = POS_W + 1;
   localparam int SQ_W   = 2 * POS_W + 1;
   localparam int DIST_W = 50;

   // One landmark as it is stored in the table memory.
   typedef struct packed {
      logic [ID_W-1:0]         id;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Control that travels beside each entry through the distance pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } pipe_ctl_type;

endpackage

// ===== rtl/nla_ram.sv =====
module nla_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nla_dist.sv =====
module nla_dist (
   input  logic                                clock,
   input  logic                                reset,
   input  nla_pkg::pipe_ctl_type               in_ctl,
   input  nla_pkg::entry_type                  entry,
   input  logic signed [nla_pkg::POS_W-1:0]    obs_x,
   input  logic signed [nla_pkg::POS_W-1:0]    obs_y,
   output nla_pkg::pipe_ctl_type               out_ctl,
   output logic [nla_pkg::ID_W-1:0]            out_id,
   output logic [nla_pkg::DIST_W-1:0]          out_dist
);

   nla_pkg::pipe_ctl_type                ctl1_ff, ctl2_ff;
   logic signed [nla_pkg::DIFF_W-1:0]    dx_ff, dy_ff;
   logic signed [nla_pkg::DIFF_W-1:0]    dx_in, dy_in;
   logic signed [2*nla_pkg::DIFF_W-1:0]  px, py;
   logic [nla_pkg::SQ_W-1:0]             sqx_ff, sqy_ff;
   logic [nla_pkg::ID_W-1:0]             id1_ff, id2_ff;

   // Stage one: coordinate differences, sign extended by one bit.
   assign dx_in = {obs_x[nla_pkg::POS_W-1], obs_x} - {entry.x[nla_pkg::POS_W-1], entry.x};
   assign dy_in = {obs_y[nla_pkg::POS_W-1], obs_y} - {entry.y[nla_pkg::POS_W-1], entry.y};

   // Stage two: squares. Each is non-negative and below 2^48.
   assign px = dx_ff * dx_ff;
   assign py = dy_ff * dy_ff;

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      id1_ff <= entry.id;
      sqx_ff <= px[nla_pkg::SQ_W-1:0];
      sqy_ff <= py[nla_pkg::SQ_W-1:0];
      id2_ff <= id1_ff;
   end

   assign out_ctl  = ctl2_ff;
   assign out_id   = id2_ff;
   assign out_dist = nla_pkg::DIST_W'(sqx_ff) + nla_pkg::DIST_W'(sqy_ff);

endmodule

// ===== rtl/nearest_landmark_association.sv =====
// Nearest-landmark association. A request is taken when start is high and busy
// is low. Clear and load requests complete in the cycle they are taken and never
// raise busy; a load into a full table is dropped and sets the sticky overflow
// flag. A query scans the landmark memory one entry per cycle through the
// registered table read and the distance pipeline; busy stays high until the
// last entry leaves the pipeline, and the result appears on the rsp_ ports with
// rsp_strobe for one cycle as busy falls. A query on an empty table answers in
// the next cycle without raising busy. Results are not held: the receiver must
// take each one in the cycle its strobe is high. Ties go to the earlier entry.
module nearest_landmark_association #(
   parameter int MAX_LANDMARKS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [nla_pkg::ID_W-1:0]          req_entry_id,
   input  logic signed [nla_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [nla_pkg::POS_W-1:0]  req_pos_y,
   output logic                              rsp_strobe,
   output logic [nla_pkg::ID_W-1:0]          rsp_assoc_id,
   output logic                              rsp_found,
   output logic [nla_pkg::DIST_W-1:0]        rsp_dist_sq,
   output logic                              rsp_overflowed
);

   localparam int CNT_W  = $clog2(MAX_LANDMARKS + 1);
   localparam int ADDR_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               ovf_ff, ovf_in;
   logic [ADDR_W-1:0]                  rd_ptr_ff, rd_ptr_in;
   nla_pkg::pipe_ctl_type              rd_ctl_ff, rd_ctl_in;
   logic                               have_ff, have_in;
   logic [nla_pkg::DIST_W-1:0]         best_d_ff, best_d_in;
   logic [nla_pkg::ID_W-1:0]           best_id_ff, best_id_in;
   logic signed [nla_pkg::POS_W-1:0]   obs_x_ff, obs_y_ff;
   logic                               obs_load;
   logic                               strobe_ff, strobe_in;
   logic [nla_pkg::ID_W-1:0]           rsp_id_ff, rsp_id_in;
   logic                               found_ff, found_in;
   logic [nla_pkg::DIST_W-1:0]         rsp_d_ff, rsp_d_in;
   logic                               rsp_ovf_ff, rsp_ovf_in;

   logic                               accept;
   logic                               table_full;
   logic                               wr_en;
   logic                               last_issue;
   logic                               better;
   nla_pkg::entry_type                 wr_entry, rd_entry;
   nla_pkg::pipe_ctl_type              d_ctl;
   logic [nla_pkg::ID_W-1:0]           d_id;
   logic [nla_pkg::DIST_W-1:0]         d_dist;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign table_full = (count_ff == CNT_W'(MAX_LANDMARKS));
   assign wr_en      = accept && (req_type == nla_pkg::REQ_LOAD) && !table_full;
   assign last_issue = ((CNT_W'(rd_ptr_ff) + CNT_W'(1)) == count_ff);

   assign wr_entry.id = req_entry_id;
   assign wr_entry.x  = req_pos_x;
   assign wr_entry.y  = req_pos_y;

   // Landmark table.
   nla_ram #(
      .WIDTH (nla_pkg::ENTRY_W),
      .DEPTH (MAX_LANDMARKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_entry)
   );

   // Distance pipeline fed by the registered table output.
   nla_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (rd_ctl_ff),
      .entry    (rd_entry),
      .obs_x    (obs_x_ff),
      .obs_y    (obs_y_ff),
      .out_ctl  (d_ctl),
      .out_id   (d_id),
      .out_dist (d_dist)
   );

   // The first entry always wins; later ones only when strictly nearer.
   assign better = !have_ff || (d_dist < best_d_ff);

   // Next-state logic for the request handling and the scan.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      rd_ptr_in  = rd_ptr_ff;
      rd_ctl_in  = '0;
      have_in    = have_ff;
      best_d_in  = best_d_ff;
      best_id_in = best_id_ff;
      obs_load   = 1'b0;
      strobe_in  = 1'b0;
      rsp_id_in  = rsp_id_ff;
      found_in   = found_ff;
      rsp_d_in   = rsp_d_ff;
      rsp_ovf_in = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  nla_pkg::REQ_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  nla_pkg::REQ_LOAD: begin
                     if (table_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  nla_pkg::REQ_QUERY: begin
                     if (count_ff == '0) begin
                        strobe_in  = 1'b1;
                        rsp_id_in  = '0;
                        found_in   = 1'b0;
                        rsp_d_in   = '0;
                        rsp_ovf_in = ovf_ff;
                     end else begin
                        state_in  = ST_SCAN;
                        rd_ptr_in = '0;
                        have_in   = 1'b0;
                        obs_load  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_ctl_in.valid = 1'b1;
            rd_ctl_in.last  = last_issue;
            rd_ptr_in       = rd_ptr_ff + ADDR_W'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Running minimum, and the result once the last entry comes out.
      if (d_ctl.valid) begin
         have_in = 1'b1;
         if (better) begin
            best_d_in  = d_dist;
            best_id_in = d_id;
         end
         if (d_ctl.last) begin
            state_in   = ST_IDLE;
            strobe_in  = 1'b1;
            rsp_id_in  = better ? d_id : best_id_ff;
            found_in   = 1'b1;
            rsp_d_in   = better ? d_dist : best_d_ff;
            rsp_ovf_in = ovf_ff;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         rd_ctl_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         rd_ctl_ff <= rd_ctl_in;
         strobe_ff <= strobe_in;
      end
      rd_ptr_ff  <= rd_ptr_in;
      have_ff    <= have_in;
      best_d_ff  <= best_d_in;
      best_id_ff <= best_id_in;
      rsp_id_ff  <= rsp_id_in;
      found_ff   <= found_in;
      rsp_d_ff   <= rsp_d_in;
      rsp_ovf_ff <= rsp_ovf_in;
      if (obs_load) begin
         obs_x_ff <= req_pos_x;
         obs_y_ff <= req_pos_y;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_assoc_id   = rsp_id_ff;
   assign rsp_found      = found_ff;
   assign rsp_dist_sq    = rsp_d_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LANDMARKS))
      else $error("entry count above table depth");

   // A result with a landmark only follows a scan.
   a_found_after_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> $past(state_ff == ST_DRAIN || state_ff == ST_SCAN))
      else $error("found result without a preceding scan");

   // Neither the entry entering nor the one leaving the distance pipeline is valid while idle.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_ctl_ff.valid && !d_ctl.valid))
      else $error("distance pipeline active while idle");

endmodule

// ===== tb/tb_nearest_landmark_association.sv =====
`timescale 1ns / 1ps

module tb_nearest_landmark_association;

   localparam int ID_W         = nla_pkg::ID_W;
   localparam int POS_W        = nla_pkg::POS_W;
   localparam int DIST_W       = nla_pkg::DIST_W;
   localparam int TABLE_DEPTH  = 64;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
   localparam int ITEM_TARGET  = 600;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // Coordinate styles used by the random phases.
   localparam int STYLE_FULL    = 0;
   localparam int STYLE_GRID    = 1;
   localparam int STYLE_CLUSTER = 2;

   // One association answer as it leaves the block.
   typedef struct {
      logic [ID_W-1:0]   assoc_id;
      logic              found;
      logic [DIST_W-1:0] dist_sq;
      logic              overflowed;
   } answer_type;

   // Mirror of the landmark table that predicts and checks each answer.
   class landmark_table_model;
      nla_pkg::entry_type table_mem[TABLE_DEPTH];
      int                 entry_count;
      bit                 overflow_flag;
      answer_type         pending_answers[$];
      int                 error_count;
      int                 query_count;
      int                 hit_count;
      int                 tie_count;
      int                 load_count;
      int                 dropped_count;

      function void note_request(input nla_pkg::req_code_type code,
                                 input logic [ID_W-1:0] id,
                                 input logic signed [POS_W-1:0] px,
                                 input logic signed [POS_W-1:0] py);
         answer_type        ans;
         longint            dx;
         longint            dy;
         longint            sum;
         logic [DIST_W-1:0] d;
         case (code)
            nla_pkg::REQ_CLEAR: begin
               entry_count   = 0;
               overflow_flag = 1'b0;
            end
            nla_pkg::REQ_LOAD: begin
               if (entry_count < TABLE_DEPTH) begin
                  table_mem[entry_count].id = id;
                  table_mem[entry_count].x  = px;
                  table_mem[entry_count].y  = py;
                  entry_count++;
                  load_count++;
               end else begin
                  overflow_flag = 1'b1;
                  dropped_count++;
               end
            end
            nla_pkg::REQ_QUERY: begin
               ans.assoc_id   = '0;
               ans.found      = 1'b0;
               ans.dist_sq    = '0;
               ans.overflowed = overflow_flag;
               // Scan in table order; a later entry wins only on a strictly smaller distance.
               for (int i = 0; i < entry_count; i++) begin
                  dx  = longint'(px) - longint'($signed(table_mem[i].x));
                  dy  = longint'(py) - longint'($signed(table_mem[i].y));
                  sum = dx * dx + dy * dy;
                  d   = sum[DIST_W-1:0];
                  if (!ans.found || d < ans.dist_sq) begin
                     ans.found    = 1'b1;
                     ans.dist_sq  = d;
                     ans.assoc_id = table_mem[i].id;
                  end else if (d == ans.dist_sq) begin
                     tie_count++;
                  end
               end
               query_count++;
               if (ans.found) begin
                  hit_count++;
               end
               pending_answers.insert(pending_answers.size(), ans);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_answer(input answer_type got);
         answer_type want;
         if (pending_answers.size() == 0) begin
            $error("Unexpected response: assoc_id=%0d found=%0d dist_sq=%0d overflowed=%0d",
                   got.assoc_id, got.found, got.dist_sq, got.overflowed);
            error_count++;
            return;
         end
         want = pending_answers.pop_front();
         if (got.assoc_id !== want.assoc_id) begin
            $error("assoc_id mismatch: expected %0d, actual %0d", want.assoc_id, got.assoc_id);
            error_count++;
         end
         if (got.found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
            error_count++;
         end
         if (got.dist_sq !== want.dist_sq) begin
            $error("dist_sq mismatch: expected %0d, actual %0d", want.dist_sq, got.dist_sq);
            error_count++;
         end
         if (got.overflowed !== want.overflowed) begin
            $error("overflowed mismatch: expected %0d, actual %0d",
                   want.overflowed, got.overflowed);
            error_count++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_type;
   logic [ID_W-1:0]          req_entry_id;
   logic signed [POS_W-1:0]  req_pos_x;
   logic signed [POS_W-1:0]  req_pos_y;
   logic                     rsp_strobe;
   logic [ID_W-1:0]          rsp_assoc_id;
   logic                     rsp_found;
   logic [DIST_W-1:0]        rsp_dist_sq;
   logic                     rsp_overflowed;

   landmark_table_model landmarks;
   int                  items_sent;
   int                  idle_cycles;
   bit                  burst_mode;

   nearest_landmark_association #(
      .MAX_LANDMARKS(TABLE_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_entry_id   (req_entry_id),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .rsp_strobe     (rsp_strobe),
      .rsp_assoc_id   (rsp_assoc_id),
      .rsp_found      (rsp_found),
      .rsp_dist_sq    (rsp_dist_sq),
      .rsp_overflowed (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly back-to-back or short gaps, with the occasional long pause.
   function automatic int pick_gap();
      int r;
      if (burst_mode) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [POS_W-1:0] pick_coord(input int style,
                                                          input logic signed [POS_W-1:0] center);
      logic signed [POS_W-1:0] c;
      int                      r;
      case (style)
         STYLE_GRID: begin
            // Coarse grid in whole metres, so equal distances come up often.
            c = POS_W'((int'($urandom_range(0, 8)) - 4) * 256);
         end
         STYLE_CLUSTER: begin
            c = center + POS_W'(int'($urandom_range(0, 4095)) - 2048);
         end
         default: begin
            r = $urandom_range(0, 9);
            case (r)
               0:       c = POS_MAX;
               1:       c = POS_MIN;
               2:       c = (($urandom_range(0, 1) == 0) ? '0 : '1);
               default: c = POS_W'($urandom());
            endcase
         end
      endcase
      return c;
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_request(input nla_pkg::req_code_type code,
                               input logic [ID_W-1:0] id,
                               input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] py);
      int gap;
      req_type     <= code;
      req_entry_id <= id;
      req_pos_x    <= px;
      req_pos_y    <= py;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (code != nla_pkg::REQ_NONE) begin
         items_sent++;
      end
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Accepted requests and responses, both sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            landmarks.check_answer('{rsp_assoc_id, rsp_found, rsp_dist_sq, rsp_overflowed});
         end
         if (start && !busy) begin
            landmarks.note_request(nla_pkg::req_code_type'(req_type), req_entry_id,
                                   req_pos_x, req_pos_y);
         end
      end
   end

   // Watchdog on cycles with neither a request taken nor a response.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int                      phase;
      int                      style;
      int                      count;
      int                      queries;
      int                      r;
      logic signed [POS_W-1:0] cx;
      logic signed [POS_W-1:0] cy;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pool_x[TABLE_DEPTH + 8];
      logic signed [POS_W-1:0] pool_y[TABLE_DEPTH + 8];

      landmarks    = new;
      items_sent   = 0;
      idle_cycles  = 0;
      burst_mode   = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_type     = nla_pkg::REQ_CLEAR;
      req_entry_id = '0;
      req_pos_x    = '0;
      req_pos_y    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, unused code, extreme ids and positions, ties.
      send_request(nla_pkg::REQ_QUERY, 16'h1234, '0, '0);
      send_request(nla_pkg::REQ_NONE, 16'hFFFF, POS_MAX, POS_MIN);
      send_request(nla_pkg::REQ_LOAD, 16'hFFFF, POS_MAX, POS_MAX);
      send_request(nla_pkg::REQ_LOAD, 16'h0000, POS_MIN, POS_MIN);
      send_request(nla_pkg::REQ_QUERY, 16'h0000, POS_MAX, POS_MAX);
      send_request(nla_pkg::REQ_QUERY, 16'hFFFF, POS_MIN, POS_MIN);
      send_request(nla_pkg::REQ_QUERY, 16'h0000, POS_MAX, POS_MIN);
      send_request(nla_pkg::REQ_QUERY, 16'h0000, '0, '0);
      send_request(nla_pkg::REQ_CLEAR, 16'hFFFF, POS_MAX, POS_MAX);
      send_request(nla_pkg::REQ_QUERY, 16'h0000, POS_MIN, POS_MAX);
      send_request(nla_pkg::REQ_LOAD, 16'd5, 24'sd256, '0);
      send_request(nla_pkg::REQ_LOAD, 16'd6, -24'sd256, '0);
      send_request(nla_pkg::REQ_LOAD, 16'd7, 24'sd256, '0);
      send_request(nla_pkg::REQ_QUERY, 16'h0000, '0, '0);
      send_request(nla_pkg::REQ_QUERY, 16'h0000, 24'sd256, '0);
      send_request(nla_pkg::REQ_QUERY, 16'h0000, -24'sd1, 24'sd1);
      send_request(nla_pkg::REQ_NONE, 16'h0000, '0, '0);
      send_request(nla_pkg::REQ_CLEAR, 16'h0000, '0, '0);
      send_request(nla_pkg::REQ_QUERY, 16'hFFFF, POS_MAX, POS_MAX);

      // Random phases: usually clear, then fill the table, then query it.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         style      = $urandom_range(STYLE_FULL, STYLE_CLUSTER);
         cx         = POS_W'($urandom());
         cy         = POS_W'($urandom());
         if ($urandom_range(0, 7) != 0) begin
            send_request(nla_pkg::REQ_CLEAR, ID_W'($urandom()), POS_W'($urandom()),
                         POS_W'($urandom()));
         end
         r = $urandom_range(0, 9);
         if (phase == 1 || r == 0) begin
            count = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 6);
         end else if (r < 3) begin
            count = $urandom_range(9, 40);
         end else begin
            count = $urandom_range(0, 8);
         end
         for (int i = 0; i < count; i++) begin
            // Some landmarks repeat an earlier position to force ties.
            if (i > 0 && $urandom_range(0, 4) == 0) begin
               r  = $urandom_range(0, i - 1);
               px = pool_x[r];
               py = pool_y[r];
            end else begin
               px = pick_coord(style, cx);
               py = pick_coord(style, cy);
            end
            pool_x[i] = px;
            pool_y[i] = py;
            send_request(nla_pkg::REQ_LOAD, ID_W'($urandom()), px, py);
            if ($urandom_range(0, 39) == 0) begin
               send_request(nla_pkg::REQ_NONE, ID_W'($urandom()), POS_W'($urandom()),
                            POS_W'($urandom()));
            end
            if ($urandom_range(0, 59) == 0) begin
               send_request(nla_pkg::REQ_QUERY, ID_W'($urandom()), px, py);
               send_request(nla_pkg::REQ_CLEAR, ID_W'($urandom()), POS_W'($urandom()),
                            POS_W'($urandom()));
            end
         end
         queries = $urandom_range(1, 6);
         for (int q = 0; q < queries; q++) begin
            if (count > 0 && $urandom_range(0, 2) == 0) begin
               r  = $urandom_range(0, (count < TABLE_DEPTH ? count : TABLE_DEPTH) - 1);
               px = pool_x[r] + POS_W'(int'($urandom_range(0, 2)) - 1);
               py = pool_y[r] + POS_W'(int'($urandom_range(0, 2)) - 1);
            end else begin
               px = pick_coord(style, cx);
               py = pick_coord(style, cy);
            end
            send_request(nla_pkg::REQ_QUERY, ID_W'($urandom()), px, py);
         end
         phase++;
      end

      // Drain the outstanding answers, then watch for stray responses.
      start <= 1'b0;
      while (landmarks.pending_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (landmarks.pending_answers.size() != 0) begin
         $error("%0d expected responses never arrived", landmarks.pending_answers.size());
         landmarks.error_count++;
      end

      $display("Sent %0d requests in %0d random phases: %0d loads, %0d dropped on a full table.",
               items_sent, phase, landmarks.load_count, landmarks.dropped_count);
      $display("Checked %0d queries, %0d with a landmark found and %0d equal-distance ties.",
               landmarks.query_count, landmarks.hit_count, landmarks.tie_count);
      if (landmarks.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== nearest_landmark_association.f =====
rtl/nla_pkg.sv
rtl/nla_ram.sv
rtl/nla_dist.sv
rtl/nearest_landmark_association.sv
tb/tb_nearest_landmark_association.sv
